// File: rtl/ubp_pkg.sv
// Shared types and constants for the unused bit picker.
`timescale 1ns / 1ps

package ubp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned BIT_W   = 3;
  localparam int unsigned SIZE_W  = 11;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accept;
    logic step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic done;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/ubp_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module ubp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ubp_ctrl.sv
// Controller state machine of the unused bit picker.
`timescale 1ns / 1ps

module ubp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ubp_pkg::sts_t sts_i,
  output ubp_pkg::cmd_t cmd_o
);

  import ubp_pkg::*;

  typedef enum logic [1:0] {
    CLEAR,
    IDLE,
    SCAN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = IDLE;
        end
      end
      IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = SCAN;
        end
      end
      SCAN: begin
        if (!sts_i.done) begin
          cmd_o.step = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = IDLE;
        end
      end
      default: begin
        state_d = CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/ubp_datapath.sv
// Datapath of the unused bit picker: size register, bitmap memory, scan and result.
`timescale 1ns / 1ps

module ubp_datapath #(
  parameter int unsigned MAX_BYTES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ubp_pkg::cmd_t                 cmd_i,
  output ubp_pkg::sts_t                 sts_o,
  input  logic                          cfg_we_i,
  input  logic [ubp_pkg::SIZE_W-1:0]    cfg_wdata_i,
  input  logic [ubp_pkg::INDEX_W-1:0]   start_byte_i,
  input  logic [ubp_pkg::BIT_W-1:0]     start_bit_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [ubp_pkg::INDEX_W-1:0]   byte_index_o,
  output logic [ubp_pkg::BIT_W-1:0]     bit_position_o,
  output ubp_pkg::status_e              status_o
);

  import ubp_pkg::*;

  localparam int unsigned AddrW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  // Configured size, saturated at the map depth.
  logic [SIZE_W-1:0] msg_q;
  logic [SIZE_W-1:0] size_w;

  // Scan state.
  logic [SIZE_W-1:0] cur_q;
  logic [SIZE_W-1:0] visit_q;
  logic [BIT_W-1:0]  sbit_q;
  logic              oor_q;
  logic [AddrW-1:0]  clr_addr_q;

  logic [SIZE_W-1:0] cur_plus;
  logic [SIZE_W-1:0] next_byte;
  logic [BYTE_W-1:0] hi_mask;
  logic [BYTE_W-1:0] mask;
  logic [BYTE_W-1:0] free_bits;
  logic [BIT_W-1:0]  pick;
  logic              found;

  // Memory ports.
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  // Result register.
  logic              out_valid_q;
  logic [INDEX_W-1:0] byte_q;
  logic [BIT_W-1:0]  bit_q;
  status_e           status_q;

  assign size_w = (32'(msg_q) > MAX_BYTES) ? SIZE_W'(MAX_BYTES) : msg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      msg_q <= cfg_wdata_i;
    end
  end

  assign cur_plus  = cur_q + SIZE_W'(1);
  assign next_byte = (cur_plus == size_w) ? '0 : cur_plus;

  // The start byte is visited twice: first from the start bit upward, and
  // after the wrap for the bits below the start bit.
  assign hi_mask = {BYTE_W{1'b1}} << sbit_q;

  always_comb begin
    if (visit_q == '0) begin
      mask = hi_mask;
    end else if (visit_q == size_w) begin
      mask = ~hi_mask;
    end else begin
      mask = {BYTE_W{1'b1}};
    end
  end

  assign free_bits = ~ram_rdata & mask;
  assign found     = |free_bits;

  always_comb begin
    pick = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        pick = BIT_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q   <= SIZE_W'(start_byte_i);
      visit_q <= '0;
      sbit_q  <= start_bit_i;
      oor_q   <= (SIZE_W'(start_byte_i) >= size_w);
    end else if (cmd_i.step) begin
      cur_q   <= next_byte;
      visit_q <= visit_q + SIZE_W'(1);
    end
  end

  assign ram_re    = cmd_i.accept | cmd_i.step;
  assign ram_raddr = cmd_i.accept ? AddrW'(start_byte_i) : AddrW'(next_byte);
  assign ram_we    = cmd_i.clear | (cmd_i.finish & ~oor_q & found);
  assign ram_waddr = cmd_i.clear ? clr_addr_q : AddrW'(cur_q);
  assign ram_wdata = cmd_i.clear ? '0 : (ram_rdata | (BYTE_W'(1) << pick));

  ubp_ram #(
    .Width(BYTE_W),
    .Depth(MAX_BYTES)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (oor_q) begin
        status_q <= STATUS_RANGE;
        byte_q   <= '0;
        bit_q    <= '0;
      end else if (found) begin
        status_q <= STATUS_OK;
        byte_q   <= cur_q[INDEX_W-1:0];
        bit_q    <= pick;
      end else begin
        status_q <= STATUS_FULL;
        byte_q   <= '0;
        bit_q    <= '0;
      end
    end
  end

  assign sts_o.clr_last = (clr_addr_q == AddrW'(MAX_BYTES - 1));
  assign sts_o.done     = oor_q | found | (visit_q == size_w);
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign byte_index_o   = byte_q;
  assign bit_position_o = bit_q;
  assign status_o       = status_q;

`ifndef SYNTH
  a_finish_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> sts_o.out_free)
    else $error("result loaded while the output register is still held");

  a_step_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> visit_q < size_w)
    else $error("scan stepped past the last byte visit");

  a_mark_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && !cmd_i.clear) |-> $countones(ram_wdata) == $countones(ram_rdata) + 1)
    else $error("map update does not mark exactly one new bit");

  a_error_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != STATUS_OK) |-> (byte_q == '0 && bit_q == '0))
    else $error("error result carries nonzero position fields");
`endif

endmodule

// File: rtl/unused_bit_picker.sv
// Top level of the unused bit picker: a find-first-zero bit allocator.
//
// The input channel (in_valid_i / in_ready_o) carries one transaction per
// request: a start byte and a start bit. The block searches upward from that
// bit for the first bit not yet marked in its bitmap, wrapping from the last
// configured byte back to byte 0, marks it, and returns one transaction on
// the output channel (out_valid_o / out_ready_i) with the byte index, the bit
// position and a status (ok, all bits used, or start byte out of range).
// The user must write the size register through cfg_we_i / cfg_wdata_i only
// while idle; the block itself does not enforce this.
// Requests are handled one at a time. If the free bit lies in the start byte,
// the map byte is read on acceptance and the result is loaded from it in the
// scan state, after which the next request can be taken. Out-of-range
// requests finish the same way. Each further byte visited adds a scan step,
// as the scan reads one map byte per cycle; a full search visits all bytes.
// A finished result sits in an output register, so a new request is taken
// while the receiver stalls; the next result then waits until it is taken.
// After reset a pass clears all MAX_BYTES map bytes, one byte per cycle,
// during which in_ready_o stays low. The size resets to 1024.
`timescale 1ns / 1ps

module unused_bit_picker #(
  parameter int unsigned MAX_BYTES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ubp_pkg::SIZE_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ubp_pkg::INDEX_W-1:0]   start_byte_i,
  input  logic [ubp_pkg::BIT_W-1:0]     start_bit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ubp_pkg::INDEX_W-1:0]   byte_index_o,
  output logic [ubp_pkg::BIT_W-1:0]     bit_position_o,
  output ubp_pkg::status_e              status_o
);

  import ubp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller sequences the clearing pass, acceptance and the scan.
  ubp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // The datapath holds the bitmap, the scan position and the result register.
  ubp_datapath #(
    .MAX_BYTES(MAX_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_byte_i  (start_byte_i),
    .start_bit_i   (start_bit_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .byte_index_o  (byte_index_o),
    .bit_position_o(bit_position_o),
    .status_o      (status_o)
  );

endmodule
